[hdl/line_pixel_rasterizer_core_assert.svh]
// Assertion helpers for the line rasterizer.
// Both take a label, a clock, a reset that disables the check, and two
// expressions: an antecedent and a consequent.
`ifndef LINE_PIXEL_RASTERIZER_CORE_ASSERT_SVH
`define LINE_PIXEL_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LPR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication failed");
// next-cycle implication
`define LPR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");
`else
`define LPR_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/lpr_pkg.sv]
package lpr_pkg;

   localparam int COLOR_BITS = 8;
   localparam int REG_BITS   = 12;

   localparam logic [REG_BITS-1:0] RESET_SCREEN_WIDTH  = 12'd800;
   localparam logic [REG_BITS-1:0] RESET_SCREEN_HEIGHT = 12'd480;

   // request kinds
   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   // register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   // step direction, two's complement
   localparam logic [1:0] DIR_NONE = 2'b00;
   localparam logic [1:0] DIR_FWD  = 2'b01;
   localparam logic [1:0] DIR_BACK = 2'b11;

   typedef struct packed {
      logic visible;
      logic last;
   } pixel_flags_type;

endpackage

[hdl/lpr_if.sv]
interface lpr_req_if #(parameter int COORD_BITS = 11);
   import lpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [COORD_BITS-1:0] start_col;
   logic [COORD_BITS-1:0] start_row;
   logic [COORD_BITS-1:0] end_col;
   logic [COORD_BITS-1:0] end_row;
   logic [COLOR_BITS-1:0] line_color;

   modport source (output valid, req_type, start_col, start_row, end_col, end_row,
                   line_color, input ready);
   modport sink (input valid, req_type, start_col, start_row, end_col, end_row,
                 line_color, output ready);
endinterface

interface lpr_rsp_if #(parameter int COORD_BITS = 11);
   import lpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_col;
   logic [COORD_BITS-1:0] pixel_row;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  pixel_visible;
   logic                  last_pixel;

   modport source (output valid, pixel_col, pixel_row, pixel_color, pixel_visible,
                   last_pixel, input ready);
   modport sink (input valid, pixel_col, pixel_row, pixel_color, pixel_visible,
                 last_pixel, output ready);
endinterface

[hdl/lpr_axis.sv]
module lpr_axis #(
   parameter int COORD_BITS = 11
) (
   input  logic                  clock,
   input  logic                  load,
   input  logic                  step,
   input  logic [COORD_BITS-1:0] from_pos,
   input  logic [COORD_BITS-1:0] to_pos,
   input  logic [COORD_BITS-1:0] major_dist,
   output logic [COORD_BITS-1:0] setup_delta,
   output logic [COORD_BITS-1:0] pos
);
   import lpr_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int SUM_BITS = COORD_BITS + 3;

   logic [COORD_BITS-1:0]      pos_ff, pos_in;
   logic signed [ERR_BITS-1:0] err_ff;
   logic [COORD_BITS-1:0]      delta_ff;
   logic [1:0]                 dir_ff, dir_new;

   logic signed [SUM_BITS-1:0] err_sum, err_in, dist_w, half_w;
   logic                       step_up;

   always_comb begin
      if (to_pos > from_pos) begin
         setup_delta = to_pos - from_pos;
         dir_new     = DIR_FWD;
      end else if (to_pos == from_pos) begin
         setup_delta = '0;
         dir_new     = DIR_NONE;
      end else begin
         setup_delta = from_pos - to_pos;
         dir_new     = DIR_BACK;
      end
   end

   always_comb begin
      dist_w  = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, major_dist});
      half_w  = $signed({{(SUM_BITS-COORD_BITS+1){1'b0}}, major_dist[COORD_BITS-1:1]});
      err_sum = SUM_BITS'(err_ff) + $signed({{(SUM_BITS-COORD_BITS){1'b0}}, delta_ff});
      step_up = (err_sum + half_w) > dist_w;
      err_in  = step_up ? (err_sum - dist_w) : err_sum;
      // wraps modulo the coordinate range
      pos_in  = step_up ? (pos_ff + {{(COORD_BITS-2){dir_ff[1]}}, dir_ff}) : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff   <= from_pos;
         err_ff   <= '0;
         delta_ff <= setup_delta;
         dir_ff   <= dir_new;
      end else if (step) begin
         pos_ff <= pos_in;
         err_ff <= err_in[ERR_BITS-1:0];
      end
   end

   assign pos = pos_ff;

endmodule

[hdl/lpr_out_stage.sv]
module lpr_out_stage #(
   parameter int COORD_BITS = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [COORD_BITS-1:0]         col,
   input  logic [COORD_BITS-1:0]         row,
   input  logic [lpr_pkg::COLOR_BITS-1:0] color,
   input  lpr_pkg::pixel_flags_type      flags,
   output logic                          room,
   lpr_rsp_if.source                     rsp_bus
);
   import lpr_pkg::*;

   logic                  valid_ff;
   logic [COORD_BITS-1:0] col_ff, row_ff;
   logic [COLOR_BITS-1:0] color_ff;
   pixel_flags_type       flags_ff;

   // free when empty or when the held beat leaves this cycle
   assign room = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (room) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (room && load) begin
         col_ff   <= col;
         row_ff   <= row;
         color_ff <= color;
         flags_ff <= flags;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.pixel_col     = col_ff;
   assign rsp_bus.pixel_row     = row_ff;
   assign rsp_bus.pixel_color   = color_ff;
   assign rsp_bus.pixel_visible = flags_ff.visible;
   assign rsp_bus.last_pixel    = flags_ff.last;

endmodule

[hdl/line_pixel_rasterizer_core.sv]
// channel   | direction | beat
// ----------+-----------+------------------------------------------------
// req_bus   | in        | start a line (endpoints, colour) or advance
// rsp_bus   | out       | one pixel: column, row, colour, visible, last
// csr_*     | in        | screen width / height write, no handshake
//
// One request beat per cycle while req_bus.ready is high; an advance on an
// active line yields its pixel in the output register in the next cycle.
// Each axis makes its Bresenham step combinationally: an add, compare and subtract.
// Reset is synchronous, active high; it idles the line and restores the
// 800 x 480 screen. A stalled pixel beat holds req_bus.ready low only while
// the output register is full and not being taken.
`include "line_pixel_rasterizer_core_assert.svh"

module line_pixel_rasterizer_core #(
   parameter int COORD_BITS = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lpr_req_if.sink                              req_bus,
   lpr_rsp_if.source                            rsp_bus,
   input  logic                                 csr_write_en,
   input  logic [lpr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lpr_pkg::REG_BITS-1:0]         csr_write_data
);
   import lpr_pkg::*;

   localparam int CMP_BITS = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;

   logic [REG_BITS-1:0]   width_ff, height_ff;
   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] index_ff, index_in;
   logic [COORD_BITS-1:0] dist_ff, dist_in;
   logic [COLOR_BITS-1:0] color_ff;

   logic                  room, accept, start, emit, last;
   logic [COORD_BITS-1:0] col_delta, row_delta, col_pos, row_pos;
   pixel_flags_type       flags;

   assign req_bus.ready = room;
   assign accept = req_bus.valid && room;
   assign start  = accept && (req_bus.req_type == REQ_START);
   assign emit   = accept && (req_bus.req_type == REQ_ADVANCE) && active_ff;
   assign last   = (index_ff == dist_ff);

   assign flags.visible = (CMP_BITS'(col_pos) < CMP_BITS'(width_ff)) &&
                          (CMP_BITS'(row_pos) < CMP_BITS'(height_ff));
   assign flags.last    = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SCREEN_WIDTH;
         height_ff <= RESET_SCREEN_HEIGHT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_write_data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   lpr_axis #(.COORD_BITS(COORD_BITS)) u_col_axis (
      .clock       (clock),
      .load        (start),
      .step        (emit),
      .from_pos    (req_bus.start_col),
      .to_pos      (req_bus.end_col),
      .major_dist  (dist_ff),
      .setup_delta (col_delta),
      .pos         (col_pos)
   );

   lpr_axis #(.COORD_BITS(COORD_BITS)) u_row_axis (
      .clock       (clock),
      .load        (start),
      .step        (emit),
      .from_pos    (req_bus.start_row),
      .to_pos      (req_bus.end_row),
      .major_dist  (dist_ff),
      .setup_delta (row_delta),
      .pos         (row_pos)
   );

   always_comb begin
      active_in = active_ff;
      index_in  = index_ff;
      dist_in   = dist_ff;
      if (start) begin
         active_in = 1'b1;
         index_in  = '0;
         dist_in   = (col_delta > row_delta) ? col_delta : row_delta;
      end else if (emit) begin
         // drop the line after its last pixel
         if (last) begin
            active_in = 1'b0;
         end else begin
            index_in = index_ff + COORD_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         index_ff  <= '0;
         dist_ff   <= '0;
      end else begin
         active_ff <= active_in;
         index_ff  <= index_in;
         dist_ff   <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         color_ff <= req_bus.line_color;
      end
   end

   lpr_out_stage #(.COORD_BITS(COORD_BITS)) u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (emit),
      .col     (col_pos),
      .row     (row_pos),
      .color   (color_ff),
      .flags   (flags),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

   `LPR_ASSERT_NXT(a_last_ends_line, clock, reset, emit && last, !active_ff)
   `LPR_ASSERT_NXT(a_start_arms_line, clock, reset, start, active_ff && (index_ff == '0))
   `LPR_ASSERT_IMP(a_index_in_range, clock, reset, active_ff, index_ff <= dist_ff)
   `LPR_ASSERT_NXT(a_idle_advance_quiet, clock, reset,
                   accept && (req_bus.req_type == REQ_ADVANCE) && !active_ff,
                   !active_ff && $stable(index_ff))

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   import lpr_pkg::*;

   localparam int COORD_BITS    = 11;
   localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
   localparam int RANDOM_ITEMS  = 1950;
   localparam int PHASES        = 6;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      coord_type col;
      coord_type row;
      color_type color;
      logic      visible;
      logic      last;
   } pixel_beat_type;

   typedef enum {DRAIN_FREE, DRAIN_COIN, DRAIN_COMB, DRAIN_TRICKLE} drain_mode_type;

   // Walks the active line one pixel per advance beat and holds the pixels still owed.
   class line_walk_checker;
      logic [REG_BITS-1:0] screen_width;
      logic [REG_BITS-1:0] screen_height;
      logic                line_active;
      coord_type           cur_col;
      coord_type           cur_row;
      int                  col_acc;
      int                  row_acc;
      coord_type           col_delta;
      coord_type           row_delta;
      logic [1:0]          col_dir;
      logic [1:0]          row_dir;
      coord_type           major_distance;
      coord_type           pixel_index;
      color_type           held_color;
      pixel_beat_type      pending_pixels[$];
      int unsigned         mismatches;

      function new();
         screen_width   = RESET_SCREEN_WIDTH;
         screen_height  = RESET_SCREEN_HEIGHT;
         line_active    = 1'b0;
         cur_col        = '0;
         cur_row        = '0;
         col_acc        = 0;
         row_acc        = 0;
         col_delta      = '0;
         row_delta      = '0;
         col_dir        = DIR_NONE;
         row_dir        = DIR_NONE;
         major_distance = '0;
         pixel_index    = '0;
         held_color     = '0;
         mismatches     = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_BITS-1:0] index,
                                   logic [REG_BITS-1:0] value);
         if (index == CSR_SCREEN_WIDTH) begin
            screen_width = value;
         end else if (index == CSR_SCREEN_HEIGHT) begin
            screen_height = value;
         end
      endfunction

      function void setup_axis(input coord_type from, input coord_type to,
                               output coord_type delta, output logic [1:0] dir);
         if (to > from) begin
            delta = to - from;
            dir   = DIR_FWD;
         end else if (to == from) begin
            delta = '0;
            dir   = DIR_NONE;
         end else begin
            delta = from - to;
            dir   = DIR_BACK;
         end
      endfunction

      function void step_axis(inout int acc, inout coord_type pos,
                              input coord_type delta, input logic [1:0] dir);
         int major;
         major = int'(major_distance);
         acc += int'(delta);
         if (acc + major / 2 > major) begin
            acc -= major;
            pos = pos + coord_type'({{(COORD_BITS-2){dir[1]}}, dir});
         end
      endfunction

      function void take_request(logic kind, coord_type c0, coord_type r0, coord_type c1,
                                 coord_type r1, color_type color);
         pixel_beat_type beat;
         if (kind == REQ_START) begin
            setup_axis(c0, c1, col_delta, col_dir);
            setup_axis(r0, r1, row_delta, row_dir);
            major_distance = (col_delta > row_delta) ? col_delta : row_delta;
            cur_col        = c0;
            cur_row        = r0;
            col_acc        = 0;
            row_acc        = 0;
            pixel_index    = '0;
            held_color     = color;
            line_active    = 1'b1;
         end else if (line_active) begin
            beat.col     = cur_col;
            beat.row     = cur_row;
            beat.color   = held_color;
            beat.visible = (cur_col < screen_width) && (cur_row < screen_height);
            beat.last    = (pixel_index == major_distance);
            pending_pixels.push_back(beat);
            step_axis(col_acc, cur_col, col_delta, col_dir);
            step_axis(row_acc, cur_row, row_delta, row_dir);
            if (beat.last) begin
               line_active = 1'b0;
            end else begin
               pixel_index = pixel_index + 1'b1;
            end
         end
      endfunction

      function void match_pixel(pixel_beat_type got);
         pixel_beat_type want;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            $error("pixel beat with nothing owed: col %0d row %0d", got.col, got.row);
            return;
         end
         want = pending_pixels.pop_front();
         if (got.col !== want.col) begin
            mismatches++;
            $error("pixel_col: expected %0d, got %0d", want.col, got.col);
         end
         if (got.row !== want.row) begin
            mismatches++;
            $error("pixel_row: expected %0d, got %0d", want.row, got.row);
         end
         if (got.color !== want.color) begin
            mismatches++;
            $error("pixel_color: expected %0d, got %0d", want.color, got.color);
         end
         if (got.visible !== want.visible) begin
            mismatches++;
            $error("pixel_visible: expected %0d, got %0d", want.visible, got.visible);
         end
         if (got.last !== want.last) begin
            mismatches++;
            $error("last_pixel: expected %0d, got %0d", want.last, got.last);
         end
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [REG_BITS-1:0]       csr_write_data;

   lpr_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   lpr_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   line_pixel_rasterizer_core #(.COORD_BITS(COORD_BITS)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   line_walk_checker walk_model = new();

   int             burst_left   = 0;
   int             drawn_items  = 0;
   int             idle_cycles  = 0;
   int             drain_tick   = 0;
   bit             progress;
   drain_mode_type drain_mode   = DRAIN_FREE;
   pixel_beat_type seen_pixel;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls: switch pattern every so often.
   always @(posedge clock) begin
      drain_tick++;
      if (drain_tick % 97 == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
      end
      case (drain_mode)
         DRAIN_FREE:  rsp_bus.ready <= 1'b1;
         DRAIN_COIN:  rsp_bus.ready <= 1'($urandom_range(0, 1));
         DRAIN_COMB:  rsp_bus.ready <= (drain_tick % 3) != 0;
         default:     rsp_bus.ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // Check the pixel before noting the request: a result never answers a beat of the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_pixel = '{rsp_bus.pixel_col, rsp_bus.pixel_row, rsp_bus.pixel_color,
                           rsp_bus.pixel_visible, rsp_bus.last_pixel};
            walk_model.match_pixel(seen_pixel);
            progress = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            walk_model.take_request(req_bus.req_type, req_bus.start_col, req_bus.start_row,
                                    req_bus.end_col, req_bus.end_row, req_bus.line_color);
            progress = 1'b1;
         end
         if (csr_write_en) begin
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_req(logic kind, coord_type c0, coord_type r0, coord_type c1,
                           coord_type r1, color_type color);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.start_col  <= c0;
      req_bus.start_row  <= r0;
      req_bus.end_col    <= c1;
      req_bus.end_row    <= r1;
      req_bus.line_color <= color;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   // Endpoint fields are don't-care on an advance: fill them with noise.
   task automatic advance_pixel();
      send_req(REQ_ADVANCE, coord_type'($urandom), coord_type'($urandom),
               coord_type'($urandom), coord_type'($urandom), color_type'($urandom));
   endtask

   task automatic draw_line(int c0, int r0, int c1, int r1, int color, int advances);
      send_req(REQ_START, coord_type'(c0), coord_type'(r0), coord_type'(c1), coord_type'(r1),
               color_type'(color));
      repeat (advances) advance_pixel();
   endtask

   function automatic int pick_coord();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   function automatic int near_coord(int base, int span);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v;
   endfunction

   task automatic random_line();
      int pick;
      int c0, r0, c1, r1;
      int dc, dr, reach, steps;
      pick = $urandom_range(0, 99);
      if (pick >= 97) begin
         // broken sequence: raw beats of either kind
         repeat ($urandom_range(1, 3)) begin
            send_req(1'($urandom), coord_type'($urandom), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), color_type'($urandom));
         end
         return;
      end
      c0 = pick_coord();
      r0 = pick_coord();
      if (pick < 90) begin
         c1 = near_coord(c0, (pick < 80) ? 12 : 100);
         r1 = near_coord(r0, (pick < 80) ? 12 : 100);
      end else begin
         c1 = pick_coord();
         r1 = pick_coord();
      end
      dc    = (c1 > c0) ? c1 - c0 : c0 - c1;
      dr    = (r1 > r0) ? r1 - r0 : r0 - r1;
      reach = (dc > dr) ? dc : dr;
      if (pick < 65 || (pick >= 80 && pick < 90)) begin
         // run to the end, sometimes poking the idle block afterwards
         steps = reach + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      end else if (pick < 80) begin
         steps = $urandom_range(0, reach);
      end else begin
         steps = $urandom_range(0, 40);
      end
      draw_line(c0, r0, c1, r1, $urandom_range(0, 255), steps);
      drawn_items += 1 + ((steps > reach + 1) ? reach + 1 : steps);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (walk_model.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen(logic [REG_BITS-1:0] width, logic [REG_BITS-1:0] height);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SCREEN_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      walk_model.write_register(CSR_SCREEN_WIDTH, width);
      csr_index      <= CSR_SCREEN_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      walk_model.write_register(CSR_SCREEN_HEIGHT, height);
      csr_write_en   <= 1'b0;
   endtask

   task automatic run_directed();
      advance_pixel();                                // no line yet
      draw_line(5, 5, 5, 5, 8'hA5, 2);                // one point, then idle again
      draw_line(COORD_MAX, COORD_MAX, 0, 0, 8'hFF, 3);
      draw_line(0, 0, 3, 1, 8'h00, 4);                // starts a new line before the long line ends
      draw_line(799, 479, 800, 480, 8'h3C, 2);        // straddles the default screen edge
      draw_line(COORD_MAX, 0, 0, COORD_MAX, 8'h81, 2);
      draw_line(2, 4, 0, 0, 8'h5A, 5);                // steep, walking back
   endtask

   logic [REG_BITS-1:0] phase_width  [PHASES] = '{12'd800, 12'd0, 12'd4095, 12'd1, 12'd2048, 12'd0};
   logic [REG_BITS-1:0] phase_height [PHASES] = '{12'd480, 12'd0, 12'd4095, 12'd2048, 12'd1, 12'd0};

   initial begin
      int phase;
      int phase_target;
      clock              = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_START;
      req_bus.start_col  = '0;
      req_bus.start_row  = '0;
      req_bus.end_col    = '0;
      req_bus.end_row    = '0;
      req_bus.line_color = '0;
      rsp_bus.ready      = 1'b0;
      csr_write_en       = 1'b0;
      csr_index          = CSR_SCREEN_WIDTH;
      csr_write_data     = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle();
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == PHASES - 1) begin
            write_screen(12'($urandom), 12'($urandom));
         end else if (phase > 0) begin
            write_screen(phase_width[phase], phase_height[phase]);
         end
         phase_target = drawn_items + RANDOM_ITEMS / PHASES;
         while (drawn_items < phase_target) random_line();
         settle();
      end

      if (walk_model.mismatches == 0 && walk_model.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[line_pixel_rasterizer_core.f]
+incdir+hdl
hdl/lpr_pkg.sv
hdl/lpr_if.sv
hdl/lpr_axis.sv
hdl/lpr_out_stage.sv
hdl/line_pixel_rasterizer_core.sv
tb/sv/tb_top.sv
